// ===== rtl/spn64_pkg.sv =====
// Shared types and codes for the 64-bit table-driven substitution-permutation cipher.
package spn64_pkg;

  localparam int TableCount   = 8;
  localparam int TableEntries = 256;
  localparam int BlockBits    = 64;

  localparam logic [1:0] CMD_LOAD_SBOX = 2'd0;
  localparam logic [1:0] CMD_LOAD_MAP  = 2'd1;
  localparam logic [1:0] CMD_ENCRYPT   = 2'd2;

  localparam logic [5:0] ROUNDS_RESET = 6'd10;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic sbox_we;
    logic map_we;
    logic rd_start;
    logic rd_next;
    logic load_out;
    logic load_bypass;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
  } dp_status_t;

endpackage

// ===== rtl/spn64_sbox_ram.sv =====
// One 256 x 8 substitution table with one write port and one registered read port.
module spn64_sbox_ram (
  input  logic       clk,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic       re,
  input  logic [7:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [spn64_pkg::TableEntries];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/spn64_datapath.sv =====
// Datapath: eight substitution tables, the bit map, the permutation network and the output register.
module spn64_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  spn64_pkg::ctrl_cmd_t   cmd,
  output spn64_pkg::dp_status_t  status,
  input  logic [2:0]             table_select,
  input  logic [7:0]             entry_index,
  input  logic [7:0]             entry_value,
  input  logic [63:0]            block_in,
  output logic [63:0]            block_out
);

  logic [7:0]  clr_cnt;
  logic [5:0]  bit_map [spn64_pkg::BlockBits];
  logic [63:0] subst;
  logic [63:0] permuted;

  // Clearing pass counter: row e of every table is written with e.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 8'd1;
    end
  end

  assign status.clear_done = (clr_cnt == 8'hFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spn64_pkg::BlockBits; i++) begin
        bit_map[i] <= 6'(i);
      end
    end else if (cmd.map_we && (entry_index[7:6] == 2'b00)) begin
      bit_map[entry_index[5:0]] <= entry_value[5:0];
    end
  end

  // Each source bit is ORed into the destination its map entry names.
  always_comb begin
    permuted = '0;
    for (int d = 0; d < spn64_pkg::BlockBits; d++) begin
      for (int b = 0; b < spn64_pkg::BlockBits; b++) begin
        permuted[d] = permuted[d] | (subst[b] & (bit_map[b] == 6'(d)));
      end
    end
  end

  for (genvar t = 0; t < spn64_pkg::TableCount; t++) begin : g_table
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;

    assign we    = cmd.clear_step || (cmd.sbox_we && (table_select == 3'(t)));
    assign waddr = cmd.clear_step ? clr_cnt : entry_index;
    assign wdata = cmd.clear_step ? clr_cnt : entry_value;
    assign raddr = cmd.rd_start ? block_in[8*t +: 8] : permuted[8*t +: 8];

    spn64_sbox_ram u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (cmd.rd_start || cmd.rd_next),
      .raddr (raddr),
      .rdata (subst[8*t +: 8])
    );
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      block_out <= permuted;
    end else if (cmd.load_bypass) begin
      block_out <= block_in;
    end
  end

endmodule

// ===== rtl/spn64_controller.sv =====
// Controller: clearing pass, command decode, round counting and output handshake.
module spn64_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             command,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   cfg_valid,
  input  logic [5:0]             cfg_rounds,
  input  spn64_pkg::dp_status_t  status,
  output spn64_pkg::ctrl_cmd_t   cmd
);

  spn64_pkg::state_t state;
  spn64_pkg::state_t state_next;
  logic [5:0]        rounds;
  logic [5:0]        cnt;
  logic [5:0]        cnt_next;
  logic              out_valid_next;
  logic              out_held;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spn64_pkg::ST_CLEAR;
      rounds    <= spn64_pkg::ROUNDS_RESET;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
      if (cfg_valid) begin
        rounds <= cfg_rounds;
      end
    end
  end

  assign out_held = out_valid && out_stall;

  always_comb begin
    in_stall = (state != spn64_pkg::ST_IDLE) ||
               ((command == spn64_pkg::CMD_ENCRYPT) && (rounds == 6'd0) && out_held);
    accept         = in_valid && !in_stall;
    cmd            = '0;
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_held;
    case (state)
      spn64_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = spn64_pkg::ST_IDLE;
        end
      end
      spn64_pkg::ST_IDLE: begin
        if (accept) begin
          case (command)
            spn64_pkg::CMD_LOAD_SBOX: cmd.sbox_we = 1'b1;
            spn64_pkg::CMD_LOAD_MAP:  cmd.map_we  = 1'b1;
            spn64_pkg::CMD_ENCRYPT: begin
              if (rounds == 6'd0) begin
                cmd.load_bypass = 1'b1;
                out_valid_next  = 1'b1;
              end else begin
                cmd.rd_start = 1'b1;
                cnt_next     = rounds;
                state_next   = spn64_pkg::ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      spn64_pkg::ST_RUN: begin
        if (cnt == 6'd1) begin
          if (!out_held) begin
            cmd.load_out   = 1'b1;
            out_valid_next = 1'b1;
            state_next     = spn64_pkg::ST_IDLE;
          end
        end else begin
          cmd.rd_next = 1'b1;
          cnt_next    = cnt - 6'd1;
        end
      end
      default: state_next = spn64_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/table_spn_block_cipher_64.sv =====
// Top level of the 64-bit table-driven substitution-permutation block cipher.
// The cipher keeps its key material as eight byte-substitution tables of 256
// entries and a 64-entry bit map, all loaded through load items on the input
// channel; a load gives no result. After reset a clearing pass writes the
// identity mapping into every table, one row of all eight tables per cycle,
// and no item is accepted until it has finished. An encrypt item runs
// round_count rounds on one shared round unit at one round per cycle: the
// eight tables are read in parallel with registered read data, and the
// permutation of that data feeds the next read addresses. After the last
// round the result is loaded into the output register, held back while an
// earlier result still waits there, and only then is the next item taken.
// The reset setting is ten rounds. With a round count of zero the block is
// passed through unchanged, and such an item is held off while a result
// waits. Loads may be taken while a result waits in the output register.
// The round count is written on the configuration channel, which is always
// ready, and must only be written while the block is idle. Bit-map loads
// with a source bit of 64 or above are ignored, as are items carrying the
// unused command code.
module table_spn_block_cipher_64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [2:0]  table_select,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  entry_value,
  input  logic [63:0] block_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] block_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  round_count
);

  spn64_pkg::ctrl_cmd_t  cmd;
  spn64_pkg::dp_status_t status;

  // Configuration writes never need to wait.
  assign cfg_ready = 1'b1;

  spn64_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_rounds (round_count),
    .status     (status),
    .cmd        (cmd)
  );

  spn64_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .table_select (table_select),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .block_in     (block_in),
    .block_out    (block_out)
  );

  // No item may be taken while the tables are still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !(in_valid && !in_stall))
    else $error("item accepted during the clearing pass");

  // A finished block must never overwrite a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out || cmd.load_bypass) |-> !(out_valid && out_stall))
    else $error("output register overwritten while stalled");

  // An encryption only starts from an accepted encrypt item.
  a_start_from_item: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_start |-> (in_valid && !in_stall && command == spn64_pkg::CMD_ENCRYPT))
    else $error("round unit started without an encrypt item");

  // Once a block is loaded into the output register it is shown the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out || cmd.load_bypass) |=> out_valid)
    else $error("result loaded but not presented");

endmodule

// ===== verif/table_spn_block_cipher_64_tb.sv =====
// Self-checking testbench for the 64-bit table-driven substitution-permutation cipher.
`timescale 1ns / 100ps

module table_spn_block_cipher_64_tb;

  // The command code that the block must ignore without a result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // The worst item combines the longest encryption with the longest sender
  // gap and receiver stall. Around 1500 such items, plus the clearing pass
  // and the drains between phases, stay well below this limit.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Idle cycles before a round count write, which covers the longest
  // encryption with room to spare.
  localparam int SETTLE_CYCLES = 80;

  localparam int PHASE_COUNT    = 7;
  localparam int RANDOM_PER_PHASE = 170;

  // Tracks the key material and round count as the block should hold them,
  // and keeps the expected ciphertexts in the order they must come out.
  class cipher_tracker;
    logic [7:0]  sbox_mem [0:spn64_pkg::TableCount*spn64_pkg::TableEntries-1];
    logic [5:0]  bit_map [0:spn64_pkg::BlockBits-1];
    logic [5:0]  rounds;
    logic [63:0] pending_ciphertext [$];
    int unsigned failures;

    function new();
      for (int e = 0; e < spn64_pkg::TableCount*spn64_pkg::TableEntries; e++)
        sbox_mem[e] = 8'(e);
      for (int b = 0; b < spn64_pkg::BlockBits; b++) bit_map[b] = 6'(b);
      rounds   = spn64_pkg::ROUNDS_RESET;
      failures = 0;
    endfunction

    // Byte substitution through the eight tables, then the bit scatter.
    // Bits that land on the same position are ORed together.
    function logic [63:0] cipher_round(logic [63:0] blk);
      logic [63:0] subst;
      logic [63:0] mixed;
      subst = '0;
      mixed = '0;
      for (int b = 0; b < spn64_pkg::TableCount; b++)
        subst[8*b +: 8] = sbox_mem[b*spn64_pkg::TableEntries + int'(blk[8*b +: 8])];
      for (int b = 0; b < spn64_pkg::BlockBits; b++)
        if (subst[b]) mixed[bit_map[b]] = 1'b1;
      return mixed;
    endfunction

    function logic [63:0] encrypt_block(logic [63:0] blk);
      logic [63:0] state;
      state = blk;
      for (int r = 0; r < int'(rounds); r++) state = cipher_round(state);
      return state;
    endfunction

    function void note_item(logic [1:0] cmd, logic [2:0] sel, logic [7:0] idx,
                            logic [7:0] val, logic [63:0] blk);
      case (cmd)
        spn64_pkg::CMD_LOAD_SBOX:
          sbox_mem[int'(sel)*spn64_pkg::TableEntries + int'(idx)] = val;
        spn64_pkg::CMD_LOAD_MAP:
          if (idx < spn64_pkg::BlockBits) bit_map[idx[5:0]] = val[5:0];
        spn64_pkg::CMD_ENCRYPT:
          pending_ciphertext.push_back(encrypt_block(blk));
        default: ;
      endcase
    endfunction

    function void check_block(logic [63:0] actual);
      logic [63:0] expected;
      if (pending_ciphertext.size() == 0) begin
        $error("block_out: expected none, actual %h", actual);
        failures++;
      end else begin
        expected = pending_ciphertext.pop_front();
        if (actual !== expected) begin
          $error("block_out: expected %h, actual %h", expected, actual);
          failures++;
        end
      end
    endfunction

    function int pending_count();
      return pending_ciphertext.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_UNUSED;
  logic [2:0]  table_select = '0;
  logic [7:0]  entry_index = '0;
  logic [7:0]  entry_value = '0;
  logic [63:0] block_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] block_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  round_count = spn64_pkg::ROUNDS_RESET;

  cipher_tracker tracker;

  // When this is low, neither side inserts gaps or stalls, so back-to-back
  // items and results are exercised too.
  bit idle_on = 1'b1;

  int unsigned cycle_count = 0;

  table_spn_block_cipher_64 i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .table_select (table_select),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .block_in     (block_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .block_out    (block_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .round_count  (round_count)
  );

  always #5 clk = ~clk;

  // Guards against a hang anywhere, including a result that never arrives.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Gap lengths for both sides: mostly none or a few cycles, now and then a
  // long one so that pauses land on every stage of an encryption.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiving side. Results are sampled at the edge on which they are taken,
  // before any flop of the block has updated, and the stall for the next
  // cycle is chosen afterwards.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) tracker.check_block(block_out);
      if (stall_left != 0) stall_left--;
      else if (idle_on) stall_left = pick_gap();
      out_stall <= (stall_left != 0);
    end
  end

  // Presents one item and waits for the block to take it. Valid is only
  // lowered when a gap is wanted, so back-to-back items keep it high and no
  // signal gets two assignments in the same step.
  task automatic send_item(input logic [1:0] cmd, input logic [2:0] sel,
                           input logic [7:0] idx, input logic [7:0] val,
                           input logic [63:0] blk);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    table_select <= sel;
    entry_index  <= idx;
    entry_value  <= val;
    block_in     <= blk;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_item(cmd, sel, idx, val, blk);
  endtask

  // The sender lowers valid and holds off until every ciphertext owed has
  // been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
  endtask

  // The round count may only change while the block is idle, so all results
  // are drained first and the block is given time to finish any last item.
  task automatic write_rounds(input logic [5:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid   <= 1'b1;
    round_count <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    tracker.rounds = value;
  endtask

  // Loads a fresh bijective bit map, which keeps the diffusion intact for the
  // encryptions that follow. The upper two bits of each value are junk that
  // the block must drop.
  task automatic load_shuffled_map();
    int perm [spn64_pkg::BlockBits];
    int j;
    int tmp;
    for (int b = 0; b < spn64_pkg::BlockBits; b++) perm[b] = b;
    for (int b = spn64_pkg::BlockBits - 1; b > 0; b--) begin
      j       = $urandom_range(0, b);
      tmp     = perm[b];
      perm[b] = perm[j];
      perm[j] = tmp;
    end
    for (int b = 0; b < spn64_pkg::BlockBits; b++)
      send_item(spn64_pkg::CMD_LOAD_MAP, 3'($urandom), 8'(b),
                {2'($urandom), 6'(perm[b])}, {$urandom, $urandom});
  endtask

  // A random item. Loads alter the key material between encryptions; a
  // share of bit-map loads aim past the 64 valid source bits and must be
  // dropped, and a few items carry the unused command code. Fields that a
  // command does not use are random throughout.
  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  cmd;
    logic [2:0]  sel;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [63:0] blk;
    pick = $urandom_range(0, 99);
    sel  = 3'($urandom);
    idx  = 8'($urandom);
    val  = 8'($urandom);
    blk  = {$urandom, $urandom};
    if (pick < 30) begin
      cmd = spn64_pkg::CMD_LOAD_SBOX;
    end else if (pick < 45) begin
      cmd = spn64_pkg::CMD_LOAD_MAP;
      if ($urandom_range(0, 4) != 0)
        idx = 8'($urandom_range(0, spn64_pkg::BlockBits - 1));
    end else if (pick < 95) begin
      cmd = spn64_pkg::CMD_ENCRYPT;
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 3))
          0: blk = '0;
          1: blk = '1;
          2: blk = 64'd1 << $urandom_range(0, 63);
          default: blk = {8{8'($urandom)}};
        endcase
      end
    end else begin
      cmd = CMD_UNUSED;
    end
    send_item(cmd, sel, idx, val, blk);
  endtask

  initial begin
    logic [5:0] plan [PHASE_COUNT];

    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset setting of ten rounds. With the identity
    // tables and map straight after the clearing pass, the cipher must be
    // transparent.
    send_item(spn64_pkg::CMD_ENCRYPT, 3'd0, 8'd0, 8'd0, 64'h0);
    send_item(spn64_pkg::CMD_ENCRYPT, 3'd7, 8'hff, 8'hff, '1);
    send_item(spn64_pkg::CMD_ENCRYPT, 3'd2, 8'h11, 8'h22, 64'h0123_4567_89ab_cdef);
    // The unused code must leave everything alone.
    send_item(CMD_UNUSED, 3'd0, 8'd0, 8'hff, '1);
    // Table loads at the corners of the select, index and value ranges.
    send_item(spn64_pkg::CMD_LOAD_SBOX, 3'd0, 8'd0, 8'hff, '0);
    send_item(spn64_pkg::CMD_LOAD_SBOX, 3'd7, 8'hff, 8'h00, '1);
    send_item(spn64_pkg::CMD_LOAD_SBOX, 3'd3, 8'h5a, 8'ha5, 64'h0);
    // Swap bits 0 and 63 of the map, with junk in the top two value bits.
    send_item(spn64_pkg::CMD_LOAD_MAP, 3'd5, 8'd0, 8'hff, '0);
    send_item(spn64_pkg::CMD_LOAD_MAP, 3'd2, 8'd63, 8'hc0, '1);
    // Source bits past the end of the map are dropped.
    send_item(spn64_pkg::CMD_LOAD_MAP, 3'd1, 8'd64, 8'd5, '0);
    send_item(spn64_pkg::CMD_LOAD_MAP, 3'd6, 8'hff, 8'd7, '0);
    send_item(spn64_pkg::CMD_ENCRYPT, 3'd0, 8'd0, 8'd0, 64'h0);
    send_item(spn64_pkg::CMD_ENCRYPT, 3'd0, 8'd0, 8'd0, '1);
    send_item(spn64_pkg::CMD_ENCRYPT, 3'd4, 8'h80, 8'h01, 64'h0123_4567_89ab_cdef);
    // Map two source bits onto one position, so their values are ORed.
    send_item(spn64_pkg::CMD_LOAD_MAP, 3'd0, 8'd1, 8'd2, '0);
    send_item(spn64_pkg::CMD_ENCRYPT, 3'd0, 8'd0, 8'd0, '1);
    send_item(spn64_pkg::CMD_ENCRYPT, 3'd0, 8'd0, 8'd0, 64'h5555_5555_5555_5555);
    send_item(CMD_UNUSED, 3'd0, 8'd1, 8'd0, '0);
    send_item(spn64_pkg::CMD_ENCRYPT, 3'd1, 8'd3, 8'd4, 64'h8000_0000_0000_0001);
    send_item(spn64_pkg::CMD_ENCRYPT, 3'd7, 8'hff, 8'hff, 64'hfedc_ba98_7654_3210);

    // Random phases. The round count runs through its extremes, including
    // zero, where the block must pass the data straight through, and the
    // deepest setting of 63 rounds.
    plan[0] = 6'd1;
    plan[1] = 6'd63;
    plan[2] = 6'd0;
    plan[3] = 6'($urandom_range(2, 62));
    plan[4] = spn64_pkg::ROUNDS_RESET;
    plan[5] = 6'($urandom_range(0, 63));
    plan[6] = 6'($urandom_range(1, 63));

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_rounds(plan[p]);
      // One phase runs with both sides flat out.
      idle_on = (p != 4);
      if (p % 2 == 0) load_shuffled_map();
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Halfway through, the sender holds back until the block has
        // emptied, so that items also meet a block that is fully idle.
        if (n == RANDOM_PER_PHASE / 2) wait_for_results();
        send_random_item();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_count() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
